>>> hdl/erd_pkg.sv
// ----------------------------------------------------------------------------
// erd_pkg
// Shared types and constants of the endpoint record deframer.
// ----------------------------------------------------------------------------
package erd_pkg;

	localparam int COUNT_W         = 10;
	localparam int SIZE_W          = COUNT_W + 1;
	localparam int ACC_W           = 17;
	localparam int PROD_W          = 20;
	localparam int HEADER_BYTES    = 2;
	localparam int MIN_RECORD_SIZE = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [ACC_W-1:0]   ACC_OVER  = 17'h10000;
	localparam logic [PROD_W-1:0]  PORT_MAX  = 20'd65535;
	localparam logic [7:0]         ASCII_0   = 8'h30;
	localparam logic [7:0]         ASCII_9   = 8'h39;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_DIGITS   = 3'd3,
		ST_ZERO     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_HOST_LEN = 2'd0,
		PH_HOST     = 2'd1,
		PH_PORT_LEN = 2'd2,
		PH_DIGITS   = 2'd3
	} phase_t;

	typedef enum logic {
		KIND_PASS    = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	// one classified byte, handed from the front to the back
	typedef struct packed {
		logic       do_digit;
		logic       emit_pass;
		logic       emit_verdict;
		logic [7:0] data;
		logic [7:0] host_len;
		status_t    len_status;
	} op_t;

endpackage

>>> hdl/erd_front.sv
// ----------------------------------------------------------------------------
// erd_front
// Tracks the record layout, classifies each byte and runs the length checks.
// ----------------------------------------------------------------------------
module erd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  logic [7:0]     data_byte,
	input  logic           last,
	input  logic           queue_full,
	output logic           push,
	output erd_pkg::op_t   push_op
);
	import erd_pkg::*;

	phase_t               phase_q, phase_d;
	logic [COUNT_W-1:0]   count_q;
	logic [7:0]           hlen_q;
	logic [7:0]           plen_q;
	logic                 accept;
	logic [7:0]           h_eff, p_eff;
	logic [SIZE_W-1:0]    cnt_ext, size, hlen_hdr, dig_idx;
	logic                 in_window;
	logic                 too_short, mismatch;

	assign item_ready = !queue_full;
	assign accept     = item_valid && item_ready;

	// header values include the current byte when it is the length byte
	assign h_eff    = (phase_q == PH_HOST_LEN) ? data_byte : hlen_q;
	assign p_eff    = (phase_q == PH_PORT_LEN) ? data_byte : plen_q;
	assign cnt_ext  = {1'b0, count_q};
	assign size     = cnt_ext + SIZE_W'(1);
	assign hlen_hdr = SIZE_W'(hlen_q) + SIZE_W'(HEADER_BYTES);
	assign dig_idx  = cnt_ext - hlen_hdr;
	assign in_window = (phase_q == PH_DIGITS) && (cnt_ext >= hlen_hdr)
		&& (dig_idx < SIZE_W'(plen_q));

	assign too_short = (size < SIZE_W'(MIN_RECORD_SIZE))
		|| ((SIZE_W'(h_eff) + SIZE_W'(HEADER_BYTES)) > size);
	assign mismatch  = (SIZE_W'(h_eff) + SIZE_W'(p_eff) + SIZE_W'(HEADER_BYTES)) != size;

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (last) begin
			phase_d = PH_HOST_LEN;
		end else begin
			case (phase_q)
				PH_HOST_LEN: begin
					phase_d = (data_byte != 8'd0) ? PH_HOST : PH_PORT_LEN;
				end
				PH_HOST: begin
					if (cnt_ext >= SIZE_W'(hlen_q))
						phase_d = PH_PORT_LEN;
				end
				PH_PORT_LEN: begin
					phase_d = PH_DIGITS;
				end
				PH_DIGITS: begin
					phase_d = PH_DIGITS;
				end
				default: begin
					phase_d = PH_HOST_LEN;
				end
			endcase
		end
	end

	// classification of the current byte
	always_comb begin
		push_op              = '0;
		push_op.data         = data_byte;
		push_op.host_len     = h_eff;
		push_op.do_digit     = in_window;
		push_op.emit_pass    = (phase_q == PH_HOST) && !last;
		push_op.emit_verdict = last;
		if (too_short)
			push_op.len_status = ST_SHORT;
		else if (mismatch)
			push_op.len_status = ST_MISMATCH;
		else if (p_eff == 8'd0)
			push_op.len_status = ST_DIGITS;
		else
			push_op.len_status = ST_OK;
		push = accept && (push_op.do_digit || push_op.emit_pass || push_op.emit_verdict);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HOST_LEN;
			count_q <= '0;
			hlen_q  <= '0;
			plen_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			if (last) begin
				count_q <= '0;
				hlen_q  <= '0;
				plen_q  <= '0;
			end else begin
				if (count_q != COUNT_MAX)
					count_q <= count_q + COUNT_W'(1);
				if (phase_q == PH_HOST_LEN)
					hlen_q <= data_byte;
				if (phase_q == PH_PORT_LEN)
					plen_q <= data_byte;
			end
		end
	end

endmodule

>>> hdl/erd_queue.sv
// ----------------------------------------------------------------------------
// erd_queue
// Small first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module erd_queue #(
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  erd_pkg::op_t push_op,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output erd_pkg::op_t head_op
);
	import erd_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	op_t              entry_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push, do_pop;

	assign full    = (fill_q == CNT_W'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head_op = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + IDX_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + IDX_W'(1);
			if (do_push && !do_pop)
				fill_q <= fill_q + CNT_W'(1);
			else if (do_pop && !do_push)
				fill_q <= fill_q - CNT_W'(1);
		end
	end

endmodule

>>> hdl/erd_back.sv
// ----------------------------------------------------------------------------
// erd_back
// Accumulates port digits, settles the verdict and holds the output register.
// ----------------------------------------------------------------------------
module erd_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         empty,
	input  erd_pkg::op_t head_op,
	output logic         pop,
	output logic         result_valid,
	input  logic         result_ready,
	output logic         kind,
	output logic [7:0]   host_byte,
	output logic [7:0]   host_length,
	output logic [15:0]  port_number,
	output logic [2:0]   status
);
	import erd_pkg::*;

	logic [ACC_W-1:0]  acc_q, acc_n;
	logic              err_q, err_n;
	logic              ovf_q, ovf_n;
	logic [PROD_W-1:0] prod;
	logic [3:0]        digit;
	logic              is_digit;
	logic              emits;
	status_t           final_status;

	logic              out_valid_q;
	logic              kind_q;
	logic [7:0]        host_byte_q;
	logic [7:0]        host_length_q;
	logic [15:0]       port_q;
	status_t           status_q;

	assign is_digit = (head_op.data >= ASCII_0) && (head_op.data <= ASCII_9);
	assign digit    = 4'(head_op.data - ASCII_0);
	// times ten as two shifted copies
	assign prod = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + PROD_W'(digit);

	always_comb begin
		acc_n = acc_q;
		err_n = err_q;
		ovf_n = ovf_q;
		if (head_op.do_digit) begin
			if (!is_digit) begin
				err_n = 1'b1;
			end else if (prod > PORT_MAX) begin
				ovf_n = 1'b1;
				acc_n = ACC_OVER;
			end else begin
				acc_n = ACC_W'(prod);
			end
		end
	end

	always_comb begin
		if (head_op.len_status != ST_OK)
			final_status = head_op.len_status;
		else if (err_n || ovf_n)
			final_status = ST_DIGITS;
		else if (acc_n == '0)
			final_status = ST_ZERO;
		else
			final_status = ST_OK;
	end

	assign emits = head_op.emit_pass || head_op.emit_verdict;
	assign pop   = !empty && (!emits || !out_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			err_q       <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head_op.emit_verdict) begin
					acc_q <= '0;
					err_q <= 1'b0;
					ovf_q <= 1'b0;
				end else begin
					acc_q <= acc_n;
					err_q <= err_n;
					ovf_q <= ovf_n;
				end
			end
			if (pop && emits)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			if (head_op.emit_verdict) begin
				kind_q        <= KIND_VERDICT;
				host_byte_q   <= '0;
				host_length_q <= head_op.host_len;
				port_q        <= (final_status == ST_OK) ? acc_n[15:0] : '0;
				status_q      <= final_status;
			end else begin
				kind_q        <= KIND_PASS;
				host_byte_q   <= head_op.data;
				host_length_q <= '0;
				port_q        <= '0;
				status_q      <= ST_OK;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = kind_q;
	assign host_byte    = host_byte_q;
	assign host_length  = host_length_q;
	assign port_number  = port_q;
	assign status       = status_q;

endmodule

>>> hdl/endpoint_record_deframer_core.sv
// ----------------------------------------------------------------------------
// endpoint_record_deframer_core
// Splits an endpoint record into host bytes and a final port verdict.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+-----------------------
//  item      | in        | item_valid / item_ready     | data_byte, last
//  result    | out       | result_valid / result_ready | kind, host_byte,
//            |           |                             | host_length,
//            |           |                             | port_number, status
//
//  one byte per cycle while the queue has room; a result passes through the byte queue and the output register
//  item_ready drops only when the byte queue holds QUEUE_DEPTH entries
//  result_ready reaches the queue pop and the output valid, and item_ready only through the queue fill
//  arst_n clears the phase, counters, accumulator, queue and output valid
// ----------------------------------------------------------------------------
module endpoint_record_deframer_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        kind,
	output logic [7:0]  host_byte,
	output logic [7:0]  host_length,
	output logic [15:0] port_number,
	output logic [2:0]  status
);
	import erd_pkg::*;

	logic queue_full, queue_empty, push, pop;
	op_t  push_op, head_op;

	erd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.data_byte  (data_byte),
		.last       (last),
		.queue_full (queue_full),
		.push       (push),
		.push_op    (push_op)
	);

	erd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (queue_full),
		.pop     (pop),
		.empty   (queue_empty),
		.head_op (head_op)
	);

	erd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (queue_empty),
		.head_op      (head_op),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.host_byte    (host_byte),
		.host_length  (host_length),
		.port_number  (port_number),
		.status       (status)
	);

endmodule

>>> hdl/erd_checker.sv
// ----------------------------------------------------------------------------
// erd_checker
// Port-level checks on the result channel of the deframer.
// ----------------------------------------------------------------------------
module erd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic        kind,
	input logic [7:0]  host_byte,
	input logic [7:0]  host_length,
	input logic [15:0] port_number,
	input logic [2:0]  status
);
	import erd_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(kind)
			&& $stable(host_byte) && $stable(host_length)
			&& $stable(port_number) && $stable(status))
		else $error("stalled result changed");

	// passthrough carries only the host byte
	a_pass_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_PASS) |->
			(host_length == 8'd0) && (port_number == 16'd0) && (status == ST_OK))
		else $error("passthrough with verdict fields set");

	// failed verdicts carry no port, ok verdicts a nonzero one
	a_port: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_VERDICT) |->
			((status == ST_OK) && (port_number != 16'd0))
			|| ((status != ST_OK) && (port_number == 16'd0)))
		else $error("verdict port inconsistent with status");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status == ST_OK) || (status == ST_SHORT)
			|| (status == ST_MISMATCH) || (status == ST_DIGITS) || (status == ST_ZERO))
		else $error("status code out of range");

endmodule

bind endpoint_record_deframer_core erd_checker u_erd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.kind         (kind),
	.host_byte    (host_byte),
	.host_length  (host_length),
	.port_number  (port_number),
	.status       (status)
);

>>> tb/tb_endpoint_record_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_endpoint_record_deframer_core
// Self-checking bench for the endpoint record deframer. A short table of
// hand-built records comes first, then random records that are mostly well
// formed with random damage mixed in, and one record past the count limit.
// Every accepted byte goes through a local model of the deframer, and each
// result transaction is compared field by field against the oldest
// prediction. Sender bursts and receiver stalls vary over the run.
// ----------------------------------------------------------------------------
module tb_endpoint_record_deframer_core;
	import erd_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int DRAIN_LIMIT  = 5000;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  host_byte;
		logic [7:0]  host_length;
		logic [15:0] port_number;
		status_t     status;
	} record_output_t;

	typedef struct packed {
		logic [7:0]     data;
		logic           lst;
		logic           typed;
		record_output_t want;
	} directed_row_t;

	typedef enum {
		DAMAGE_DIGIT,
		DAMAGE_PORT_LEN,
		DAMAGE_EXTRA,
		DAMAGE_CUT
	} damage_t;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_BURSTY
	} sink_mode_t;

	localparam record_output_t NO_VERDICT = '0;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	logic [7:0]  data_byte    = 8'h00;
	logic        last         = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        kind;
	logic [7:0]  host_byte;
	logic [7:0]  host_length;
	logic [15:0] port_number;
	logic [2:0]  status;

	// local copy of the record state
	phase_t       rec_phase    = PH_HOST_LEN;
	logic [9:0]   rec_count    = '0;
	logic [7:0]   rec_host_len = '0;
	logic [7:0]   rec_port_len = '0;
	logic [16:0]  rec_port_acc = '0;
	logic         rec_bad_char = 1'b0;
	logic         rec_overflow = 1'b0;

	record_output_t deframer_outputs_due[$];
	logic [8:0]     record_stream[$];
	int             error_count = 0;
	int             burst_left  = 0;
	logic [31:0]    sink_cycle  = '0;
	sink_mode_t     sink_mode   = SINK_OPEN;

	directed_row_t directed_rows [29] = '{
		// lone header byte at its maximum
		'{8'hFF, 1'b1, 1'b1, '{KIND_VERDICT, 8'h00, 8'hFF, 16'd0, ST_SHORT}},
		// smallest good record
		'{8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{8'h01, 1'b0, 1'b0, NO_VERDICT},
		'{8'h37, 1'b1, 1'b1, '{KIND_VERDICT, 8'h00, 8'h00, 16'd7, ST_OK}},
		// port zero
		'{8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{8'h01, 1'b0, 1'b0, NO_VERDICT},
		'{8'h30, 1'b1, 1'b1, '{KIND_VERDICT, 8'h00, 8'h00, 16'd0, ST_ZERO}},
		// largest port behind one host byte
		'{8'h01, 1'b0, 1'b0, NO_VERDICT},
		'{8'hFF, 1'b0, 1'b0, NO_VERDICT},
		'{8'h05, 1'b0, 1'b0, NO_VERDICT},
		'{8'h36, 1'b0, 1'b0, NO_VERDICT},
		'{8'h35, 1'b0, 1'b0, NO_VERDICT},
		'{8'h35, 1'b0, 1'b0, NO_VERDICT},
		'{8'h33, 1'b0, 1'b0, NO_VERDICT},
		'{8'h35, 1'b1, 1'b1, '{KIND_VERDICT, 8'h00, 8'h01, 16'hFFFF, ST_OK}},
		// no digits at all
		'{8'h01, 1'b0, 1'b0, NO_VERDICT},
		'{8'h78, 1'b0, 1'b0, NO_VERDICT},
		'{8'h00, 1'b1, 1'b1, '{KIND_VERDICT, 8'h00, 8'h01, 16'd0, ST_DIGITS}},
		// record ends inside the host name
		'{8'h02, 1'b0, 1'b0, NO_VERDICT},
		'{8'h41, 1'b0, 1'b0, NO_VERDICT},
		'{8'h42, 1'b1, 1'b1, '{KIND_VERDICT, 8'h00, 8'h02, 16'd0, ST_SHORT}},
		// sign character among the digits
		'{8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{8'h02, 1'b0, 1'b0, NO_VERDICT},
		'{8'h2B, 1'b0, 1'b0, NO_VERDICT},
		'{8'h31, 1'b1, 1'b1, '{KIND_VERDICT, 8'h00, 8'h00, 16'd0, ST_DIGITS}},
		// trailing byte past the digits
		'{8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{8'h01, 1'b0, 1'b0, NO_VERDICT},
		'{8'h35, 1'b0, 1'b0, NO_VERDICT},
		'{8'h35, 1'b1, 1'b1, '{KIND_VERDICT, 8'h00, 8'h00, 16'd0, ST_MISMATCH}}
	};

	endpoint_record_deframer_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.data_byte    (data_byte),
		.last         (last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.host_byte    (host_byte),
		.host_length  (host_length),
		.port_number  (port_number),
		.status       (status)
	);

	always #5 clk = ~clk;

	// advances the local record state by one byte; returns 1 when a result is due
	function automatic bit deframe_byte(input logic [7:0] b, input logic lst,
		output record_output_t r);
		int unsigned idx;
		int unsigned size;
		int unsigned h;
		int unsigned p;
		int unsigned v;
		status_t     st;
		bit          pass;
		idx  = rec_count;
		pass = 1'b0;
		r    = '0;
		case (rec_phase)
			PH_HOST_LEN: begin
				rec_host_len = b;
				rec_phase    = (b != 0) ? PH_HOST : PH_PORT_LEN;
			end
			PH_HOST: begin
				pass = 1'b1;
				if (idx >= rec_host_len)
					rec_phase = PH_PORT_LEN;
			end
			PH_PORT_LEN: begin
				rec_port_len = b;
				rec_phase    = PH_DIGITS;
			end
			default: begin
				// only the first P bytes after the port length are digits
				if (idx >= rec_host_len + HEADER_BYTES &&
						idx - rec_host_len - HEADER_BYTES < rec_port_len) begin
					if (b < ASCII_0 || b > ASCII_9) begin
						rec_bad_char = 1'b1;
					end else begin
						v = rec_port_acc * 10 + (b - ASCII_0);
						if (v > 65535) begin
							rec_overflow = 1'b1;
							v = 65536;
						end
						rec_port_acc = 17'(v);
					end
				end
			end
		endcase
		rec_count = (idx + 1 > COUNT_MAX) ? COUNT_MAX : 10'(idx + 1);

		if (lst) begin
			h    = rec_host_len;
			p    = rec_port_len;
			size = idx + 1;
			if (size < MIN_RECORD_SIZE || h + HEADER_BYTES > size)
				st = ST_SHORT;
			else if (h + p + HEADER_BYTES != size)
				st = ST_MISMATCH;
			else if (p == 0 || rec_bad_char || rec_overflow)
				st = ST_DIGITS;
			else if (rec_port_acc == 0)
				st = ST_ZERO;
			else
				st = ST_OK;
			r.kind        = KIND_VERDICT;
			r.host_length = rec_host_len;
			r.port_number = (st == ST_OK) ? rec_port_acc[15:0] : 16'd0;
			r.status      = st;
			rec_phase     = PH_HOST_LEN;
			rec_count     = '0;
			rec_host_len  = '0;
			rec_port_len  = '0;
			rec_port_acc  = '0;
			rec_bad_char  = 1'b0;
			rec_overflow  = 1'b0;
			return 1'b1;
		end
		if (pass) begin
			r.kind      = KIND_PASS;
			r.host_byte = b;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	// drives one byte, with a possible gap between bursts, then predicts its result
	task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
		input record_output_t typed_out);
		record_output_t predicted;
		bit             has_out;
		int             gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		data_byte  <= b;
		last       <= lst;
		// ready is looked at mid-cycle so the next rising edge is the accepting one
		@(negedge clk);
		while (!item_ready) @(negedge clk);
		@(posedge clk);
		has_out = deframe_byte(b, lst, predicted);
		if (typed)
			predicted = typed_out;
		if (has_out)
			deframer_outputs_due.push_back(predicted);
	endtask

	// builds one record into record_stream; long_one gives a record past the count limit
	task automatic build_record(input bit long_one);
		logic [7:0]  rec[$];
		int unsigned shape;
		int unsigned host_len;
		int unsigned port_len;
		int unsigned n;
		damage_t     damage;
		shape = $urandom_range(0, 99);
		if (shape < 10 && !long_one) begin
			n = $urandom_range(1, 6);
			repeat (n) rec.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 99);
			if (long_one || n >= 98)
				host_len = long_one ? 255 : $urandom_range(200, 255);
			else if (n < 60)
				host_len = $urandom_range(0, 6);
			else
				host_len = $urandom_range(7, 40);
			port_len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
			rec.push_back(8'(host_len));
			repeat (host_len) rec.push_back(8'($urandom_range(0, 255)));
			rec.push_back(8'(port_len));
			// now and then an all-zero port
			n = $urandom_range(0, 9);
			repeat (port_len)
				rec.push_back((n == 0) ? ASCII_0 : 8'(ASCII_0 + $urandom_range(0, 9)));
			if (long_one) begin
				n = $urandom_range(1026, 1060);
				while (rec.size() < n) rec.push_back(8'($urandom_range(0, 255)));
			end else if (shape < 35) begin
				damage = damage_t'($urandom_range(0, 3));
				case (damage)
					DAMAGE_DIGIT: begin
						if (port_len != 0)
							rec[host_len + 2 + $urandom_range(0, port_len - 1)] =
								8'($urandom_range(0, 255));
					end
					DAMAGE_PORT_LEN: begin
						rec[host_len + 1] = $urandom_range(0, 1) ? 8'(port_len + 1)
							: 8'(port_len - 1);
					end
					DAMAGE_EXTRA: begin
						repeat ($urandom_range(1, 3)) rec.push_back(8'($urandom_range(0, 255)));
					end
					default: begin
						n = $urandom_range(1, rec.size());
						while (rec.size() > n) void'(rec.pop_back());
					end
				endcase
			end
		end
		foreach (rec[i])
			record_stream.push_back({i == rec.size() - 1, rec[i]});
	endtask

	// receiver: the stall pattern is drawn anew whenever the low byte of sink_cycle is zero
	always @(posedge clk) begin
		sink_cycle <= sink_cycle + 1;
		if (sink_cycle[7:0] == 8'd0)
			sink_mode <= sink_mode_t'($urandom_range(0, 3));
		case (sink_mode)
			SINK_OPEN:   result_ready <= 1'b1;
			SINK_COIN:   result_ready <= $urandom_range(0, 1);
			SINK_SPARSE: result_ready <= (sink_cycle % 3 == 0);
			default:     result_ready <= (sink_cycle[4:0] >= 5'd20);
		endcase
	end

	// result checker
	always @(posedge clk) begin
		record_output_t want;
		if (arst_n && result_valid && result_ready) begin
			if (deframer_outputs_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d status %0d",
					kind, status));
			end else begin
				want = deframer_outputs_due.pop_front();
				compare_field("kind", kind, want.kind);
				compare_field("host_byte", host_byte, want.host_byte);
				compare_field("host_length", host_length, want.host_length);
				compare_field("port_number", port_number, want.port_number);
				compare_field("status", status, want.status);
			end
		end
	end

	initial begin
		int         random_items;
		int         drain;
		bit         long_now;
		bit         long_done;
		logic [8:0] entry;
		random_items = 0;
		long_done    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].data, directed_rows[i].lst, directed_rows[i].typed,
				directed_rows[i].want);

		while (random_items < RANDOM_ITEMS) begin
			long_now = !long_done && random_items >= RANDOM_ITEMS / 8;
			build_record(long_now);
			if (long_now)
				long_done = 1'b1;
			while (record_stream.size() != 0) begin
				entry = record_stream.pop_front();
				send_byte(entry[7:0], entry[8], 1'b0, NO_VERDICT);
				random_items++;
			end
		end
		item_valid <= 1'b0;

		drain = 0;
		while (deframer_outputs_due.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (deframer_outputs_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived",
				deframer_outputs_due.size()));

		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// hang guard
	initial begin
		#8_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> files.f
hdl/erd_pkg.sv
hdl/erd_front.sv
hdl/erd_queue.sv
hdl/erd_back.sv
hdl/endpoint_record_deframer_core.sv
hdl/erd_checker.sv
tb/tb_endpoint_record_deframer_core.sv
